FILE: hw/rtl/sfla_pkg.sv
// Shared constants, types and helpers of the segment free-list allocator.
package sfla_pkg;

  localparam int unsigned MAX_SEGMENTS = 1024;

  localparam int unsigned IDX_W     = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W     = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned SIZE_W    = 31;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned CLIENT_W  = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = IDX_W + SIZE_W;
  localparam int unsigned DIV_CNT_W = $clog2(ADDR_W);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [STATUS_W-1:0]  status_t;

  // register indexes
  localparam cfg_idx_t REG_AREA_BASE     = 2'd0;
  localparam cfg_idx_t REG_SEGMENT_BYTES = 2'd1;
  localparam cfg_idx_t REG_SEGMENT_COUNT = 2'd2;
  localparam cfg_idx_t REG_RESERVED      = 2'd3;

  // register reset values
  localparam logic [SIZE_W-1:0]  SEG_BYTES_RST = 31'd1048576;
  localparam logic [COUNT_W-1:0] SEG_COUNT_RST = 11'd1024;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NO_SEG   = 2'd1;
  localparam status_t ST_BAD_ADDR = 2'd2;

  // segments actually managed: programmed count clipped to the bound
  function automatic logic [CNT_W-1:0] eff_count(logic [COUNT_W-1:0] seg);
    if (32'(seg) > 32'(MAX_SEGMENTS)) begin
      return CNT_W'(MAX_SEGMENTS);
    end else begin
      return CNT_W'(seg);
    end
  endfunction

endpackage

FILE: hw/rtl/sfla_if.sv
// Request and response channel interfaces of the segment allocator.
interface sfla_req_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [sfla_pkg::CLIENT_W-1:0]     client_id;
  logic [sfla_pkg::ADDR_W-1:0]       free_address;

  modport source (output valid, kind, client_id, free_address, input ready);
  modport sink   (input valid, kind, client_id, free_address, output ready);
endinterface

interface sfla_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [sfla_pkg::STATUS_W-1:0]     status;
  logic [sfla_pkg::ADDR_W-1:0]       segment_address;
  logic [sfla_pkg::CLIENT_W-1:0]     owner;
  logic [sfla_pkg::COUNT_W-1:0]      free_count;
  logic                              consistent;

  modport source (output valid, status, segment_address, owner, free_count, consistent,
                  input ready);
  modport sink   (input valid, status, segment_address, owner, free_count, consistent,
                  output ready);
endinterface

FILE: hw/rtl/segment_free_list_allocator.sv
// Top level of the segment free-list allocator.
// Hands out fixed-size segments from a FIFO free list held in on-chip RAM.
// req_i carries one request per beat (kind 0 allocate, kind 1 free);
// rsp_o returns exactly one result beat per request, in request order.
// A segment address is area_base + index * segment_bytes (48-bit wrap).
// Allocate: queue RAM read, one multiply, one add, then the result is
// registered; a refused allocate goes straight to the result. Free: the
// 48-step bit-serial divider turns the address offset into an index, then
// a used-bit read follows unless the offset fails the alignment or range check.
// One request is in flight at a time; req_i.ready is high only while idle,
// so no new request is taken before the last one has been handed on.
// The result sits in an output register; a stalled receiver holds it and
// the next request is accepted meanwhile, its result waiting until the
// register frees.
// After reset, and after any write to area_base, segment_bytes or
// segment_count, a clearing pass over MAX_SEGMENTS entries (1024 by default)
// reloads the queue with ascending indices and clears every used bit;
// no request is accepted during it. reserved_count writes take effect at once.
// Write configuration only while the block is idle; the block does not check.
module segment_free_list_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sfla_pkg::ADDR_W-1:0]       cfg_data_i,
  sfla_req_if.sink                          req_i,
  sfla_rsp_if.source                        rsp_o
);

  localparam int unsigned IDX_W  = sfla_pkg::IDX_W;
  localparam int unsigned CNT_W  = sfla_pkg::CNT_W;
  localparam int unsigned ADDR_W = sfla_pkg::ADDR_W;
  localparam int unsigned SIZE_W = sfla_pkg::SIZE_W;
  localparam int unsigned PROD_W = sfla_pkg::PROD_W;

  // state codes
  localparam logic [3:0] S_CLEAR = 4'd0;  // sweep both RAMs
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_QRD   = 4'd2;  // queue head read returning
  localparam logic [3:0] S_ADD   = 4'd3;  // base + product
  localparam logic [3:0] S_DIV   = 4'd4;  // offset / size running
  localparam logic [3:0] S_URD   = 4'd5;  // used bit read returning
  localparam logic [3:0] S_OUT   = 4'd6;  // hand result to output register

  // configuration registers
  logic [ADDR_W-1:0]            area_base_q;
  logic [SIZE_W-1:0]            seg_bytes_q;
  logic [sfla_pkg::COUNT_W-1:0] seg_count_q;
  logic [sfla_pkg::COUNT_W-1:0] reserved_q;

  logic [3:0]        state_q, state_d;
  logic [IDX_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  used_q, used_d;

  // per-request working registers
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [PROD_W-1:0]             prod_q, prod_d;
  sfla_pkg::status_t             status_q, status_d;
  logic [ADDR_W-1:0]             addr_q, addr_d;
  logic [sfla_pkg::CLIENT_W-1:0] owner_q, owner_d;

  // output register
  logic                          rsp_valid_q, rsp_valid_d;
  sfla_pkg::status_t             rsp_status_q, rsp_status_d;
  logic [ADDR_W-1:0]             rsp_addr_q, rsp_addr_d;
  logic [sfla_pkg::CLIENT_W-1:0] rsp_owner_q, rsp_owner_d;
  logic [sfla_pkg::COUNT_W-1:0]  rsp_free_q, rsp_free_d;
  logic                          rsp_cons_q, rsp_cons_d;

  // RAMs: free queue and used bits, registered read
  logic [IDX_W-1:0] queue_mem [sfla_pkg::MAX_SEGMENTS];
  logic             in_use_mem [sfla_pkg::MAX_SEGMENTS];

  logic             q_we, q_re;
  logic [IDX_W-1:0] q_waddr, q_wdata, q_rdata_q;
  logic             u_we, u_re, u_wdata, u_rdata_q;
  logic [IDX_W-1:0] u_waddr, u_raddr;

  // divider
  logic              div_start, div_done;
  logic [ADDR_W-1:0] div_quo;
  logic [SIZE_W-1:0] div_rem;

  logic [CNT_W-1:0]  n_eff;
  logic [SIZE_W-1:0] size_eff;
  logic              alloc_fail;
  logic              geom_write;
  logic              out_free;

  assign n_eff      = sfla_pkg::eff_count(seg_count_q);
  assign size_eff   = (seg_bytes_q == '0) ? SIZE_W'(1) : seg_bytes_q;
  assign alloc_fail = (32'(fill_q) <= 32'(reserved_q)) || (fill_q == '0);
  assign geom_write = cfg_we_i && (cfg_index_i != sfla_pkg::REG_RESERVED);
  assign out_free   = !rsp_valid_q || rsp_o.ready;

  sfla_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (req_i.free_address - area_base_q),
    .divisor_i   (size_eff),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    used_d    = used_q;
    idx_d     = idx_q;
    prod_d    = prod_q;
    status_d  = status_q;
    addr_d    = addr_q;
    owner_d   = owner_q;

    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_addr_d   = rsp_addr_q;
    rsp_owner_d  = rsp_owner_q;
    rsp_free_d   = rsp_free_q;
    rsp_cons_d   = rsp_cons_q;

    q_we    = 1'b0;
    q_waddr = tail_q;
    q_wdata = idx_q;
    q_re    = 1'b0;
    u_we    = 1'b0;
    u_waddr = idx_q;
    u_wdata = 1'b0;
    u_re    = 1'b0;
    u_raddr = div_quo[IDX_W-1:0];
    div_start = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        q_we    = 1'b1;
        q_waddr = clr_cnt_q;
        q_wdata = clr_cnt_q;
        u_we    = 1'b1;
        u_waddr = clr_cnt_q;
        u_wdata = 1'b0;
        clr_cnt_d = clr_cnt_q + IDX_W'(1);
        if (clr_cnt_q == IDX_W'(sfla_pkg::MAX_SEGMENTS - 1)) begin
          head_d  = '0;
          tail_d  = '0;
          fill_d  = n_eff;
          used_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          addr_d  = '0;
          owner_d = '0;
          if (req_i.kind == sfla_pkg::KIND_ALLOC) begin
            if (alloc_fail) begin
              status_d = sfla_pkg::ST_NO_SEG;
              state_d  = S_OUT;
            end else begin
              q_re    = 1'b1;
              owner_d = req_i.client_id;
              state_d = S_QRD;
            end
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_QRD: begin
        idx_d   = q_rdata_q;
        prod_d  = PROD_W'(q_rdata_q) * PROD_W'(size_eff);
        u_we    = 1'b1;
        u_waddr = q_rdata_q;
        u_wdata = 1'b1;
        head_d  = (CNT_W'(head_q) + CNT_W'(1) == n_eff) ? '0 : head_q + IDX_W'(1);
        fill_d  = fill_q - CNT_W'(1);
        used_d  = used_q + CNT_W'(1);
        state_d = S_ADD;
      end
      S_ADD: begin
        addr_d   = area_base_q + ADDR_W'(prod_q);
        status_d = sfla_pkg::ST_OK;
        state_d  = S_OUT;
      end
      S_DIV: begin
        if (div_done) begin
          if ((div_rem != '0) || (div_quo >= ADDR_W'(n_eff))) begin
            status_d = sfla_pkg::ST_BAD_ADDR;
            state_d  = S_OUT;
          end else begin
            u_re    = 1'b1;
            idx_d   = div_quo[IDX_W-1:0];
            state_d = S_URD;
          end
        end
      end
      S_URD: begin
        if (!u_rdata_q) begin
          status_d = sfla_pkg::ST_BAD_ADDR;
        end else begin
          // release: clear used bit, push index at the tail
          u_we     = 1'b1;
          u_waddr  = idx_q;
          u_wdata  = 1'b0;
          q_we     = 1'b1;
          q_waddr  = tail_q;
          q_wdata  = idx_q;
          tail_d   = (CNT_W'(tail_q) + CNT_W'(1) == n_eff) ? '0 : tail_q + IDX_W'(1);
          fill_d   = fill_q + CNT_W'(1);
          used_d   = used_q - CNT_W'(1);
          status_d = sfla_pkg::ST_OK;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_addr_d   = addr_q;
          rsp_owner_d  = owner_q;
          rsp_free_d   = sfla_pkg::COUNT_W'(fill_q);
          rsp_cons_d   = ((CNT_W+1)'(fill_q) + (CNT_W+1)'(used_q)) == (CNT_W+1)'(n_eff);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase

    // geometry change restarts the clearing pass
    if (geom_write) begin
      state_d   = S_CLEAR;
      clr_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
      area_base_q <= '0;
      seg_bytes_q <= sfla_pkg::SEG_BYTES_RST;
      seg_count_q <= sfla_pkg::SEG_COUNT_RST;
      reserved_q  <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      used_q      <= used_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sfla_pkg::REG_AREA_BASE:     area_base_q <= cfg_data_i;
          sfla_pkg::REG_SEGMENT_BYTES: seg_bytes_q <= cfg_data_i[SIZE_W-1:0];
          sfla_pkg::REG_SEGMENT_COUNT: seg_count_q <= cfg_data_i[sfla_pkg::COUNT_W-1:0];
          sfla_pkg::REG_RESERVED:      reserved_q  <= cfg_data_i[sfla_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    prod_q       <= prod_d;
    status_q     <= status_d;
    addr_q       <= addr_d;
    owner_q      <= owner_d;
    rsp_status_q <= rsp_status_d;
    rsp_addr_q   <= rsp_addr_d;
    rsp_owner_q  <= rsp_owner_d;
    rsp_free_q   <= rsp_free_d;
    rsp_cons_q   <= rsp_cons_d;
  end

  // free queue RAM
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata_q <= queue_mem[head_q];
    end
  end

  // used-bit RAM
  always_ff @(posedge clk_i) begin
    if (u_we) begin
      in_use_mem[u_waddr] <= u_wdata;
    end
    if (u_re) begin
      u_rdata_q <= in_use_mem[u_raddr];
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_status_q;
  assign rsp_o.segment_address = rsp_addr_q;
  assign rsp_o.owner           = rsp_owner_q;
  assign rsp_o.free_count      = rsp_free_q;
  assign rsp_o.consistent      = rsp_cons_q;

endmodule

FILE: hw/rtl/sfla_div.sv
// Bit-serial restoring divider: address offset by segment size.
module sfla_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sfla_pkg::ADDR_W-1:0]   dividend_i,
  input  logic [sfla_pkg::SIZE_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [sfla_pkg::ADDR_W-1:0]   quotient_o,
  output logic [sfla_pkg::SIZE_W-1:0]   remainder_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [sfla_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [sfla_pkg::ADDR_W-1:0]       quo_q, quo_d;
  logic [sfla_pkg::SIZE_W-1:0]       rem_q, rem_d;
  logic [sfla_pkg::SIZE_W-1:0]       div_q, div_d;
  logic [sfla_pkg::SIZE_W:0]         trial;
  logic                              ge;

  // one quotient bit per cycle, MSB first; quotient shifts in behind the dividend
  assign trial = {rem_q, quo_q[sfla_pkg::ADDR_W-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[sfla_pkg::ADDR_W-2:0], ge};
      rem_d = ge ? sfla_pkg::SIZE_W'(trial - {1'b0, div_q})
                 : trial[sfla_pkg::SIZE_W-1:0];
      cnt_d = cnt_q + sfla_pkg::DIV_CNT_W'(1);
      if (cnt_q == sfla_pkg::DIV_CNT_W'(sfla_pkg::ADDR_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

FILE: tb/sfla_allocation_checker.sv
// Checker for the segment allocator: mirrors the free list and compares every result beat.
`timescale 1ns / 1ps
module sfla_allocation_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sfla_pkg::ADDR_W-1:0]      cfg_data_i,
  sfla_req_if                              req_i,
  sfla_rsp_if                              rsp_i,
  output int                               mismatch_count_o,
  output int                               results_owed_o
);
  import sfla_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [CLIENT_W-1:0] owner;
    logic [COUNT_W-1:0]  free_count;
    logic                consistent;
  } grant_t;

  // mirrored registers
  logic [ADDR_W-1:0]  base_r;
  logic [SIZE_W-1:0]  size_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] reserve_r;

  // mirrored free list and used map
  logic [IDX_W-1:0] ring [MAX_SEGMENTS];
  logic             in_use_map [MAX_SEGMENTS];
  int unsigned      ring_head, ring_tail, ring_fill, used_segs;

  grant_t owed_q [$];
  int     mismatches;

  function automatic int unsigned managed_segs();
    return (int'(count_r) > int'(MAX_SEGMENTS)) ? MAX_SEGMENTS : int'(count_r);
  endfunction

  function automatic void reload_list();
    int unsigned n;
    n = managed_segs();
    for (int unsigned i = 0; i < MAX_SEGMENTS; i++) begin
      ring[i]       = (i < n) ? IDX_W'(i) : '0;
      in_use_map[i] = 1'b0;
    end
    ring_head = 0;
    ring_tail = 0;
    ring_fill = n;
    used_segs = 0;
  endfunction

  // one request in, the result it must produce out; updates the mirror
  function automatic grant_t serve_request(logic kind, logic [CLIENT_W-1:0] client,
                                           logic [ADDR_W-1:0] addr);
    grant_t      g;
    int unsigned n;
    logic [63:0] sz, off, q;
    logic [IDX_W-1:0] idx;
    n  = managed_segs();
    sz = (size_r == '0) ? 64'd1 : 64'(size_r);
    g  = '0;
    g.status = ST_OK;
    if (kind == KIND_ALLOC) begin
      if (ring_fill <= int'(reserve_r) || ring_fill == 0 || n == 0) begin
        g.status = ST_NO_SEG;
      end else begin
        idx        = ring[ring_head];
        ring_head  = (ring_head + 1) % n;
        ring_fill -= 1;
        in_use_map[idx] = 1'b1;
        used_segs += 1;
        g.alloc_addr = ADDR_W'(64'(base_r) + 64'(idx) * sz);
        g.owner      = client;
      end
    end else begin
      off = 64'(ADDR_W'(addr - base_r));
      q   = off / sz;
      if ((off % sz) != 0 || q >= 64'(n) || !in_use_map[q[IDX_W-1:0]]) begin
        g.status = ST_BAD_ADDR;
      end else begin
        in_use_map[q[IDX_W-1:0]] = 1'b0;
        used_segs -= 1;
        ring[ring_tail] = q[IDX_W-1:0];
        ring_tail  = (ring_tail + 1) % n;
        ring_fill += 1;
      end
    end
    g.free_count = COUNT_W'(ring_fill);
    g.consistent = (ring_fill + used_segs == n);
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      base_r    = '0;
      size_r    = SEG_BYTES_RST;
      count_r   = SEG_COUNT_RST;
      reserve_r = '0;
      reload_list();
      owed_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_AREA_BASE: begin
            base_r = cfg_data_i;
            reload_list();
          end
          REG_SEGMENT_BYTES: begin
            size_r = cfg_data_i[SIZE_W-1:0];
            reload_list();
          end
          REG_SEGMENT_COUNT: begin
            count_r = cfg_data_i[COUNT_W-1:0];
            reload_list();
          end
          REG_RESERVED: begin
            reserve_r = cfg_data_i[COUNT_W-1:0];
          end
          default: ;
        endcase
      end
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        owed_q.push_back(serve_request(req_i.kind, req_i.client_id, req_i.free_address));
      end
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (owed_q.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            mismatches++;
          end
          if (rsp_i.segment_address !== want.alloc_addr) begin
            $error("segment_address: expected %0h, got %0h", want.alloc_addr,
                   rsp_i.segment_address);
            mismatches++;
          end
          if (rsp_i.owner !== want.owner) begin
            $error("owner: expected %0h, got %0h", want.owner, rsp_i.owner);
            mismatches++;
          end
          if (rsp_i.free_count !== want.free_count) begin
            $error("free_count: expected %0d, got %0d", want.free_count, rsp_i.free_count);
            mismatches++;
          end
          if (rsp_i.consistent !== want.consistent) begin
            $error("consistent: expected %0b, got %0b", want.consistent, rsp_i.consistent);
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    results_owed_o   <= owed_q.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the segment allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import sfla_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  int mismatches;
  int results_owed;

  // idling switches and the one long receiver hold-off (cycles)
  bit          sender_idles;
  bit          receiver_idles;
  int unsigned receiver_hold;

  // geometry as last programmed, used to aim free requests at real segments
  logic [ADDR_W-1:0] cur_base;
  logic [63:0]       cur_size;
  int unsigned       cur_count;

  sfla_req_if req_ch ();
  sfla_rsp_if rsp_ch ();

  segment_free_list_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  // watches both channels and the register port, predicts and compares
  sfla_allocation_checker u_alloc_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .req_i            (req_ch),
    .rsp_i            (rsp_ch),
    .mismatch_count_o (mismatches),
    .results_owed_o   (results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop; the slowest legal run is far shorter than this
  initial begin
    #20_000_000;
    $display("segment_free_list_allocator regression: fail");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (receiver_hold != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (receiver_hold) @(posedge clk_i);
        receiver_hold = 0;
      end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request beat and hold it until accepted. valid stays high on
  // return so back-to-back beats never drop it; an idle burst lowers it first.
  task automatic send(logic kind, logic [CLIENT_W-1:0] client, logic [ADDR_W-1:0] addr);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.client_id    <= client;
    req_ch.free_address <= addr;
    @(posedge clk_i);
    while (req_ch.ready !== 1'b1) @(posedge clk_i);
  endtask

  // allocate: free_address is don't-care, so fill it with noise
  task automatic claim_seg(logic [CLIENT_W-1:0] client);
    send(KIND_ALLOC, client, {16'($urandom), $urandom});
  endtask

  task automatic free_seg(logic [ADDR_W-1:0] addr);
    send(KIND_FREE, 16'($urandom), addr);
  endtask

  // Stop offering and wait until every result is back. The first edge lets
  // the owed count catch up with a beat accepted at the current edge.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [ADDR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
  endtask

  // Program all four registers after draining the block. Bits above each
  // register's width carry junk that the block must drop.
  task automatic program_regs(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size,
                              logic [COUNT_W-1:0] count, logic [COUNT_W-1:0] reserve);
    drain();
    write_reg(REG_AREA_BASE, base);
    write_reg(REG_SEGMENT_BYTES, {17'($urandom), size});
    write_reg(REG_SEGMENT_COUNT, {5'($urandom), $urandom, count});
    write_reg(REG_RESERVED, {5'($urandom), $urandom, reserve});
    cfg_we    <= 1'b0;
    cur_base  = base;
    cur_size  = (size == '0) ? 64'd1 : 64'(size);
    cur_count = (int'(count) > int'(MAX_SEGMENTS)) ? MAX_SEGMENTS : int'(count);
  endtask

  function automatic logic [ADDR_W-1:0] addr_of_seg(int unsigned idx);
    return ADDR_W'(64'(cur_base) + 64'(idx) * cur_size);
  endfunction

  // One random request: mostly well-formed allocates and frees aimed at
  // segment boundaries, the rest noise, misaligned or out-of-range frees.
  task automatic random_request(int unsigned alloc_pct);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      free_seg({16'($urandom), $urandom});
    end else if (pick < 14) begin
      if (cur_size > 1) begin
        free_seg(addr_of_seg($urandom_range(0, cur_count)) +
                 ADDR_W'($urandom_range(1, 32'(cur_size - 1))));
      end else begin
        free_seg(addr_of_seg(cur_count + $urandom_range(0, 3)));
      end
    end else if ($urandom_range(0, 99) < alloc_pct) begin
      claim_seg(16'($urandom));
    end else begin
      free_seg(addr_of_seg($urandom_range(0, cur_count)));
    end
  endtask

  initial begin
    logic [ADDR_W-1:0]  r_base;
    logic [SIZE_W-1:0]  r_size;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_reserve;
    int unsigned        alloc_pct;

    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_AREA_BASE;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.kind         <= KIND_ALLOC;
    req_ch.client_id    <= '0;
    req_ch.free_address <= '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    receiver_hold  = 0;
    cur_base  = '0;
    cur_size  = 64'(SEG_BYTES_RST);
    cur_count = int'(SEG_COUNT_RST);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed part ---
    // Reset geometry: client id extremes, a good free, a double free,
    // a misaligned address, one segment past the end, the top address.
    claim_seg('0);
    claim_seg('1);
    free_seg(48'h0);
    free_seg(48'h0);
    free_seg(48'h1);
    free_seg(48'h4000_0000);
    free_seg('1);

    // Base at the very top and largest size: addresses wrap past 2^48.
    // Three segments, so the fourth allocate finds the list empty.
    program_regs('1, 31'h4000_0000, 11'd3, 11'd0);
    claim_seg(16'h0001);
    claim_seg(16'h8000);
    claim_seg(16'h7FFF);
    claim_seg(16'h1234);
    free_seg(48'h3FFF_FFFF);
    free_seg('1);
    claim_seg(16'hA5A5);

    // Zero size behaves as one byte; reservation holds back two of four.
    program_regs('0, '0, 11'd4, 11'd2);
    claim_seg(16'h0002);
    claim_seg(16'h0003);
    claim_seg(16'h0004);
    free_seg(48'h1);
    free_seg(48'h5);

    // No segments at all: nothing to allocate, nothing valid to free.
    program_regs(48'h1234_5678_9ABC, 31'd1, 11'd0, 11'd0);
    claim_seg(16'h0005);
    free_seg(48'h1234_5678_9ABC);

    // Count beyond the bound clips to it; reserving the whole list blocks allocation.
    program_regs('0, 31'd1, 11'h7FF, 11'd1024);
    claim_seg(16'h0006);
    free_seg(48'd1023);
    free_seg(48'd1024);

    // --- random part: twelve settings, about 127 beats each ---
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: r_base = {16'($urandom), $urandom};
        6:                r_base = '0;
        7:                r_base = '1;
        default:          r_base = ADDR_W'($urandom_range(0, 4096));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: r_size = SIZE_W'($urandom_range(1, 16));
        4:          r_size = SIZE_W'(32'd1 << $urandom_range(0, 30));
        5:          r_size = SIZE_W'($urandom_range(1, 32'h4000_0000));
        6:          r_size = '0;
        7:          r_size = 31'h4000_0000;
        default:    r_size = SIZE_W'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: r_count = COUNT_W'($urandom_range(1, 48));
        6:                r_count = COUNT_W'($urandom_range(2, 300));
        7:                r_count = 11'd1024;
        8:                r_count = COUNT_W'($urandom_range(1025, 2047));
        default:          r_count = COUNT_W'($urandom_range(0, 2));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: r_reserve = '0;
        6, 7:             r_reserve = COUNT_W'($urandom_range(1, 3));
        8:                r_reserve = r_count;
        default:          r_reserve = COUNT_W'($urandom_range(0, 2047));
      endcase
      alloc_pct = $urandom_range(35, 70);

      // last part of the run runs flat out on both sides
      if (ph == 11) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end
      program_regs(r_base, r_size, r_count, r_reserve);

      for (int k = 0; k < 127; k++) begin
        // receiver stops for a long stretch; sender keeps offering so
        // the output register fills and the request side backs up
        if (ph == 2 && k == 40) receiver_hold = 300;
        // sender stops until every result is home, then carries on
        if (ph == 5 && k == 60) drain();
        random_request(alloc_pct);
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("segment_free_list_allocator regression: pass");
    end else begin
      $display("segment_free_list_allocator regression: fail");
    end
    $finish;
  end

endmodule
